>>> src/fafcs_pkg.sv
// shared types, constants and helpers for the fully associative cache trace simulator
// no dependencies; imported by fafcs_cache, fifo_fully_associative_cache_sim and tb
package fafcs_pkg;

  localparam int unsigned LINES = 8;
  localparam int unsigned PTR_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(9);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LINES - 1);

  typedef logic [ADDR_W-1:0] tag_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic is_instruction;
    logic [ADDR_W-1:0] access_address;
  } access_t;

  typedef struct packed {
    logic unified_hit;
    logic split_hit;
    count_t unified_hit_total;
    count_t instruction_hit_total;
    count_t instruction_access_total;
    count_t data_hit_total;
    count_t data_access_total;
  } result_t;

  // holds at all ones instead of wrapping
  function automatic count_t sat_inc(input count_t v);
    sat_inc = (&v) ? v : v + count_t'(1);
  endfunction

endpackage

>>> src/fafcs_cache.sv
// one fully associative cache: tags, valid bits, round-robin victim pointer
// depends on fafcs_pkg
module fafcs_cache import fafcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic lookup,
  input  tag_t lookup_tag,
  output logic hit
);

  tag_t tags [LINES];
  logic [LINES-1:0] valid;
  logic [PTR_W-1:0] victim_ptr;
  logic [PTR_W-1:0] victim_ptr_next;
  logic [LINES-1:0] match;

  // parallel compare against every line
  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      match[i] = valid[i] && (tags[i] == lookup_tag);
    end
  end

  assign hit = |match;
  assign victim_ptr_next = (victim_ptr == PTR_LAST) ? '0 : victim_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      victim_ptr <= '0;
    end else if (lookup && !hit) begin
      valid[victim_ptr] <= 1'b1;
      victim_ptr <= victim_ptr_next;
    end
  end

  // tag storage, no reset: only read behind a valid bit
  always_ff @(posedge clk) begin
    if (lookup && !hit) begin
      tags[victim_ptr] <= lookup_tag;
    end
  end

endmodule

>>> src/fifo_fully_associative_cache_sim.sv
// a beat is registered into in_tag, looked up, and its result registered on rsp with done high
// throughput: one access per cycle; busy stays low, start may be high in every cycle
// the receiver cannot stall: done marks each result on rsp for exactly one cycle
// reset (rst, synchronous): valid bits, victim pointers, counts and strobes cleared,
// line_offset_bits back to 9; tag storage is not cleared
module fifo_fully_associative_cache_sim import fafcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [SHIFT_W-1:0] cfg_data,
  input  logic start,
  output logic busy,
  input  access_t req,
  output logic done,
  output result_t rsp
);

  // configuration register
  logic [SHIFT_W-1:0] line_offset_bits;

  // input register stage
  logic in_valid;
  logic in_instr;
  tag_t in_tag;

  // lookup results
  logic uni_hit;
  logic ins_hit;
  logic dat_hit;
  logic split_hit;

  // running counts
  count_t unified_hit_count;
  count_t instr_hit_count;
  count_t instr_access_count;
  count_t data_hit_count;
  count_t data_access_count;
  count_t unified_hit_count_next;
  count_t instr_hit_count_next;
  count_t instr_access_count_next;
  count_t data_hit_count_next;
  count_t data_access_count_next;

  // no stage can stall, so the block never holds off a beat
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_offset_bits <= SHIFT_RESET;
    end else if (cfg_we) begin
      line_offset_bits <= cfg_data;
    end
  end

  // take the beat and form the tag right away; the user must change offset only while idle, unchecked here
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_instr <= req.is_instruction;
      in_tag <= req.access_address >> line_offset_bits;
    end
  end

  // unified cache sees every access, split caches only their own kind
  fafcs_cache u_unified (
    .clk        (clk),
    .rst        (rst),
    .lookup     (in_valid),
    .lookup_tag (in_tag),
    .hit        (uni_hit)
  );

  fafcs_cache u_instr (
    .clk        (clk),
    .rst        (rst),
    .lookup     (in_valid && in_instr),
    .lookup_tag (in_tag),
    .hit        (ins_hit)
  );

  fafcs_cache u_data (
    .clk        (clk),
    .rst        (rst),
    .lookup     (in_valid && !in_instr),
    .lookup_tag (in_tag),
    .hit        (dat_hit)
  );

  assign split_hit = in_instr ? ins_hit : dat_hit;

  // saturating count updates, this access included
  always_comb begin
    unified_hit_count_next = unified_hit_count;
    instr_hit_count_next = instr_hit_count;
    instr_access_count_next = instr_access_count;
    data_hit_count_next = data_hit_count;
    data_access_count_next = data_access_count;
    if (in_valid) begin
      if (uni_hit) begin
        unified_hit_count_next = sat_inc(unified_hit_count);
      end
      if (in_instr) begin
        instr_access_count_next = sat_inc(instr_access_count);
        if (ins_hit) begin
          instr_hit_count_next = sat_inc(instr_hit_count);
        end
      end else begin
        data_access_count_next = sat_inc(data_access_count);
        if (dat_hit) begin
          data_hit_count_next = sat_inc(data_hit_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unified_hit_count <= '0;
      instr_hit_count <= '0;
      instr_access_count <= '0;
      data_hit_count <= '0;
      data_access_count <= '0;
      done <= 1'b0;
    end else begin
      unified_hit_count <= unified_hit_count_next;
      instr_hit_count <= instr_hit_count_next;
      instr_access_count <= instr_access_count_next;
      data_hit_count <= data_hit_count_next;
      data_access_count <= data_access_count_next;
      done <= in_valid;
    end
  end

  // result register, one beat per access
  always_ff @(posedge clk) begin
    if (in_valid) begin
      rsp.unified_hit <= uni_hit;
      rsp.split_hit <= split_hit;
      rsp.unified_hit_total <= unified_hit_count_next;
      rsp.instruction_hit_total <= instr_hit_count_next;
      rsp.instruction_access_total <= instr_access_count_next;
      rsp.data_hit_total <= data_hit_count_next;
      rsp.data_access_total <= data_access_count_next;
    end
  end

endmodule

>>> tb/tb.sv
// self-checking testbench for fifo_fully_associative_cache_sim: a short directed table,
// then random access phases under several line offsets, checked against a local cache model
// depends on fafcs_pkg (access_t, result_t, widths) and the top-level RTL
module tb;
  import fafcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with neither an accepted access nor a result before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 103;
  localparam int POOL_MAX = 16;

  typedef enum int {
    UNIFIED_CACHE = 0,
    INSTR_CACHE   = 1,
    DATA_CACHE    = 2
  } cache_id_t;

  typedef struct {
    access_t beat;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we = 1'b0;
  logic [SHIFT_W-1:0] cfg_data = '0;
  logic            start = 1'b0;
  logic            busy;
  access_t         req = '0;
  logic            done;
  result_t         rsp;

  fifo_fully_associative_cache_sim DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp)
  );

  // 12 ns period, high phase first
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // cache model: three tag stores with valid bits and round-robin victims
  // ---------------------------------------------------------------------------
  tag_t             cache_tags [3][LINES];
  bit               cache_valid[3][LINES];
  logic [PTR_W-1:0] victim_ptr [3];
  logic [SHIFT_W-1:0] line_shift;
  count_t           unified_hits;
  count_t           instr_hits;
  count_t           instr_accesses;
  count_t           data_hits;
  count_t           data_accesses;

  // results still owed by the block, oldest first
  result_t          pending_results[$];
  directed_row_t    directed_rows[$];
  int               mismatches = 0;
  int               idle_cycles = 0;
  int               item_no = 0;

  // counts hold at all ones
  function automatic count_t bump(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  // look the tag up; on a miss write it at the victim line and advance the pointer
  function automatic bit probe_and_fill(input cache_id_t id, input tag_t t);
    int i;
    for (i = 0; i < LINES; i++) begin
      if (cache_valid[id][i] && cache_tags[id][i] == t) return 1'b1;
    end
    cache_tags[id][victim_ptr[id]] = t;
    cache_valid[id][victim_ptr[id]] = 1'b1;
    victim_ptr[id] = (victim_ptr[id] == PTR_LAST) ? '0 : victim_ptr[id] + PTR_W'(1);
    return 1'b0;
  endfunction

  function automatic result_t predict_access(input access_t a);
    result_t r;
    tag_t    t;
    t = a.access_address >> line_shift;
    r.unified_hit = probe_and_fill(UNIFIED_CACHE, t);
    if (r.unified_hit) unified_hits = bump(unified_hits);
    if (a.is_instruction) begin
      r.split_hit = probe_and_fill(INSTR_CACHE, t);
      instr_accesses = bump(instr_accesses);
      if (r.split_hit) instr_hits = bump(instr_hits);
    end else begin
      r.split_hit = probe_and_fill(DATA_CACHE, t);
      data_accesses = bump(data_accesses);
      if (r.split_hit) data_hits = bump(data_hits);
    end
    r.unified_hit_total        = unified_hits;
    r.instruction_hit_total    = instr_hits;
    r.instruction_access_total = instr_accesses;
    r.data_hit_total           = data_hits;
    r.data_access_total        = data_accesses;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: every done beat is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no access outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("unified_hit", 32'(want.unified_hit), 32'(rsp.unified_hit));
        check_field("split_hit", 32'(want.split_hit), 32'(rsp.split_hit));
        check_field("unified_hit_total", want.unified_hit_total, rsp.unified_hit_total);
        check_field("instruction_hit_total", want.instruction_hit_total,
                    rsp.instruction_hit_total);
        check_field("instruction_access_total", want.instruction_access_total,
                    rsp.instruction_access_total);
        check_field("data_hit_total", want.data_hit_total, rsp.data_hit_total);
        check_field("data_access_total", want.data_access_total, rsp.data_access_total);
      end
    end
  end

  // watchdog: counts cycles in which no beat moves in either direction
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  // present a beat and hold it until the block takes it; start is left high so
  // that a back-to-back beat can follow without a bubble
  task automatic issue_access(input access_t a, input bit typed, input result_t typed_want);
    result_t model;
    start <= 1'b1;
    req   <= a;
    do @(posedge clk); while (busy);
    // the model always advances, even when the expected value is typed in
    model = predict_access(a);
    pending_results.push_back(typed ? typed_want : model);
    item_no++;
  endtask

  // random sender bubble, about 15 in a hundred, none inside the quiet stretch
  task automatic sender_gap();
    int n;
    if (item_no >= 350 && item_no < 560) return;
    if ($urandom_range(99) >= 15) return;
    n = $urandom_range(1, 5);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and wait until the block has returned every result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // the register is only touched with nothing in flight
  task automatic set_offset(input logic [SHIFT_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_shift = v;
  endtask

  task automatic add_row(input logic instr, input logic [ADDR_W-1:0] addr, input bit typed,
                         input logic uh, input logic sh, input count_t uht, input count_t iht,
                         input count_t iat, input count_t dht, input count_t dat);
    directed_row_t row;
    row.beat.is_instruction = instr;
    row.beat.access_address = addr;
    row.typed = typed;
    row.want.unified_hit = uh;
    row.want.split_hit = sh;
    row.want.unified_hit_total = uht;
    row.want.instruction_hit_total = iht;
    row.want.instruction_access_total = iat;
    row.want.data_hit_total = dht;
    row.want.data_access_total = dat;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [SHIFT_W-1:0] offsets[$];
    tag_t               line_pool[POOL_MAX];
    tag_t               low_mask;
    access_t            a;
    int                 pool_size;
    int                 r;
    int                 p;
    int                 k;

    // model starts from the reset state: shift 9, nothing valid, counts clear
    line_shift = SHIFT_RESET;
    for (k = 0; k < 3; k++) begin
      victim_ptr[k] = '0;
      for (p = 0; p < LINES; p++) begin
        cache_valid[k][p] = 1'b0;
        cache_tags[k][p] = '0;
      end
    end
    unified_hits = '0;
    instr_hits = '0;
    instr_accesses = '0;
    data_hits = '0;
    data_accesses = '0;

    // directed table at the reset offset of 9 (512-byte lines); typed rows are
    // the ones that follow from the reset state at a glance
    add_row(1'b1, 32'h0000_0000, 1, 0, 0, 0, 0, 1, 0, 0);  // cold miss everywhere
    add_row(1'b1, 32'h0000_01FF, 1, 1, 1, 1, 1, 2, 0, 0);  // same line, top byte
    add_row(1'b0, 32'h0000_0000, 1, 1, 0, 2, 1, 2, 0, 1);  // unified hit, data cold
    add_row(1'b0, 32'hFFFF_FFFF, 1, 0, 0, 2, 1, 2, 0, 2);  // all-ones address
    add_row(1'b0, 32'hFFFF_FE00, 1, 1, 1, 3, 1, 2, 1, 3);  // same top line
    add_row(1'b1, 32'hFFFF_FE01, 1, 1, 0, 4, 1, 3, 1, 3);  // split caches are separate
    add_row(1'b1, 32'h0000_0200, 1, 0, 0, 4, 1, 4, 1, 3);  // next line up
    // fill the unified cache past eight lines so the oldest line is replaced
    add_row(1'b0, 32'h0000_0400, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b1, 32'h0000_0600, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b0, 32'h0000_0800, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b1, 32'h0000_0A00, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b0, 32'h0000_0C00, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b1, 32'h0000_0E00, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b0, 32'h0000_0000, 0, 0, 0, 0, 0, 0, 0, 0);  // evicted from unified
    add_row(1'b1, 32'h0000_0201, 0, 0, 0, 0, 0, 0, 0, 0);  // still resident
    add_row(1'b0, 32'hAAAA_5555, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b1, 32'h5555_AAAA, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1'b1, 32'hFFFF_FE00, 0, 0, 0, 0, 0, 0, 0, 0);  // now in the instr cache
    add_row(1'b0, 32'hAAAA_5400, 0, 0, 0, 0, 0, 0, 0, 0);  // same line as earlier beat

    // offsets for the random phases: both extremes, the reset value, odd ones;
    // tags stored under one offset stay in place across the change
    offsets = '{5'd0, 5'd31, 5'd9, 5'd4, SHIFT_W'($urandom_range(31)), 5'd16, 5'd1,
                5'd30, SHIFT_W'($urandom_range(31)), 5'd0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      issue_access(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
      sender_gap();
    end

    foreach (offsets[ph]) begin
      set_offset(offsets[ph]);
      low_mask = (tag_t'(1) << offsets[ph]) - tag_t'(1);
      // a small pool of lines per phase, sometimes under eight (mostly hits),
      // sometimes over (steady round-robin thrashing)
      pool_size = $urandom_range(3, POOL_MAX - 2);
      for (p = 0; p < POOL_MAX; p++) line_pool[p] = $urandom;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        a.is_instruction = 1'($urandom_range(1));
        if (r < 10) begin
          a.access_address = $urandom;
        end else begin
          // a few hot lines get most of the traffic
          p = (r < 45) ? $urandom_range(2) : $urandom_range(pool_size - 1);
          a.access_address = line_pool[p] ^ ($urandom & low_mask);
        end
        issue_access(a, 1'b0, '0);
        // now and then let the block empty completely before the next beat
        if ($urandom_range(99) < 2) drain();
        else sender_gap();
      end
    end

    // wait for the last results, then a few cycles more for any stray beat
    drain();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
